@@ design/swt_pkg.sv @@
// shared types and constants for the sorted waypoint table unit
// no dependencies

package swt_pkg;

    localparam int ID_W    = 16;
    localparam int COORD_W = 32;
    localparam int AC_W    = 8;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_DEL = 2'd1;
    localparam logic [1:0] FUNC_NAV = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] east;
        logic [COORD_W-1:0] north;
        logic [COORD_W-1:0] up;
    } entry_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_SHUP  = 7'b0000100,
        ST_SHDN  = 7'b0001000,
        ST_NAV0  = 7'b0010000,
        ST_NAV1  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

endpackage

@@ design/sorted_waypoint_table_unit.sv @@
// sorted waypoint table: top level with entry memory and sequencer
// depends on swt_pkg

// One transaction enters on start while busy is low; exactly one result comes back
// on done for one cycle, and the receiver cannot stall it. All entries live in one
// single-port synchronous memory with a registered read, so the sequencer walks
// it entry by entry: an add or delete scans for its position and then shifts the
// entries behind it; an add whose id is already present overwrites that entry in
// place instead. A navigate step reads the current entry and, if there is one, the
// entry before it. A foreign message or unused code goes straight to the result.
// No clearing pass after reset.
module sorted_waypoint_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic                          cfg_we,
    input  logic [swt_pkg::AC_W-1:0]      cfg_wdata,
    input  logic [1:0]                    func,
    input  logic [swt_pkg::AC_W-1:0]      target_aircraft,
    input  logic [swt_pkg::ID_W-1:0]      waypoint_id,
    input  logic signed [31:0]            east,
    input  logic signed [31:0]            north,
    input  logic signed [31:0]            up,
    input  logic                          reached,
    output logic                          accepted,
    output logic                          success,
    output logic [6:0]                    path_index,
    output logic [6:0]                    entry_count,
    output logic [swt_pkg::ID_W-1:0]      echo_id,
    output logic                          route_mode,
    output logic signed [31:0]            from_east,
    output logic signed [31:0]            from_north,
    output logic signed [31:0]            from_up,
    output logic signed [31:0]            to_east,
    output logic signed [31:0]            to_north,
    output logic signed [31:0]            to_up
);
    import swt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // entry memory
    entry_t mem [TABLE_DEPTH];
    entry_t rd_data;
    logic   mem_re, mem_we;
    logic [AW-1:0] mem_addr;
    entry_t wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= wr_data;
        if (mem_re)
            rd_data <= mem[mem_addr];
    end

    state_t state_reg, state_next;
    logic [AC_W-1:0] own_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] pos_reg, pos_next;   // scan / shift pointer
    logic          phase_reg, phase_next; // 0 issue read, 1 data back
    logic [1:0]    func_reg;
    entry_t        cmd_reg;
    logic          reached_reg;
    entry_t        prev_reg, prev_next;
    logic          ok_reg, ok_next, acc_reg, acc_next;
    logic [CW-1:0] tgt_reg, tgt_next;   // insert position

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_reg <= '0;
        else if (cfg_we)
            own_reg <= cfg_wdata;
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        prev_next  = prev_reg;
        ok_next    = ok_reg;
        acc_next   = acc_reg;
        tgt_next   = tgt_reg;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = pos_reg[AW-1:0];
        wr_data    = cmd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pos_next   = '0;
                    phase_next = 1'b0;
                    ok_next    = 1'b0;
                    acc_next   = 1'b0;
                    if ((func == FUNC_ADD || func == FUNC_DEL) &&
                        target_aircraft == own_reg)
                    begin
                        acc_next   = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else if (func == FUNC_NAV)
                    begin
                        acc_next = 1'b1;
                        if (count_reg != '0 && cur_reg < count_reg)
                        begin
                            ok_next    = 1'b1;
                            pos_next   = cur_reg;
                            state_next = ST_NAV0;
                        end
                        else
                            state_next = ST_DONE;
                    end
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (!phase_reg)
                begin
                    if (pos_reg >= count_reg)
                    begin
                        // reached the end without a hit
                        if (func_reg == FUNC_ADD && count_reg < CW'(TABLE_DEPTH))
                        begin
                            ok_next  = 1'b1;
                            tgt_next = pos_reg;
                            pos_next = count_reg;
                            state_next = ST_SHUP;
                        end
                        else
                            state_next = ST_DONE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        phase_next = 1'b1;
                    end
                end
                else
                begin
                    phase_next = 1'b0;
                    if (func_reg == FUNC_ADD)
                    begin
                        if (rd_data.id == cmd_reg.id)
                        begin
                            mem_we     = 1'b1;
                            ok_next    = 1'b1;
                            state_next = ST_DONE;
                        end
                        else if (rd_data.id > cmd_reg.id)
                        begin
                            if (count_reg < CW'(TABLE_DEPTH))
                            begin
                                ok_next    = 1'b1;
                                tgt_next   = pos_reg;
                                pos_next   = count_reg;
                                state_next = ST_SHUP;
                            end
                            else
                                state_next = ST_DONE;
                        end
                        else
                            pos_next = pos_reg + 1'b1;
                    end
                    else
                    begin
                        if (rd_data.id == cmd_reg.id)
                        begin
                            ok_next    = 1'b1;
                            pos_next   = pos_reg + 1'b1;
                            state_next = ST_SHDN;
                        end
                        else
                            pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_SHUP:
            begin
                // pos = destination, copies pos-1 into pos down to tgt, then writes the new entry at tgt
                if (pos_reg == tgt_reg)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (tgt_reg < cur_reg && cur_reg < CW'(TABLE_DEPTH))
                        cur_next = cur_reg + 1'b1;
                    state_next = ST_DONE;
                end
                else if (!phase_reg)
                begin
                    mem_re     = 1'b1;
                    mem_addr   = AW'(pos_reg - 1'b1);
                    phase_next = 1'b1;
                end
                else
                begin
                    mem_we     = 1'b1;
                    wr_data    = rd_data;
                    phase_next = 1'b0;
                    pos_next   = pos_reg - 1'b1;
                end
            end
            ST_SHDN:
            begin
                // pos = source, copies pos into pos-1
                if (pos_reg >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
                else if (!phase_reg)
                begin
                    mem_re     = 1'b1;
                    phase_next = 1'b1;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_addr   = AW'(pos_reg - 1'b1);
                    wr_data    = rd_data;
                    phase_next = 1'b0;
                    pos_next   = pos_reg + 1'b1;
                end
            end
            ST_NAV0:
            begin
                // read current, then previous if any
                if (!phase_reg)
                begin
                    mem_re     = 1'b1;
                    phase_next = 1'b1;
                end
                else
                begin
                    prev_next  = rd_data;
                    phase_next = 1'b0;
                    state_next = ST_NAV1;
                    if (cur_reg != '0)
                    begin
                        mem_re   = 1'b1;
                        mem_addr = AW'(cur_reg - 1'b1);
                    end
                end
            end
            ST_NAV1:
            begin
                if (reached_reg)
                    cur_next = cur_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            cur_reg   <= '0;
            pos_reg   <= '0;
            phase_reg <= 1'b0;
            ok_reg    <= 1'b0;
            acc_reg   <= 1'b0;
            tgt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            ok_reg    <= ok_next;
            acc_reg   <= acc_next;
            tgt_reg   <= tgt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        if (start && !busy)
        begin
            func_reg      <= func;
            reached_reg   <= reached;
            cmd_reg.id    <= waypoint_id;
            cmd_reg.east  <= east;
            cmd_reg.north <= north;
            cmd_reg.up    <= up;
        end
    end

    // result register: one cycle strobe
    logic nav_res;
    logic res_valid_reg;
    logic res_acc_reg, res_ok_reg, res_route_reg;
    logic [6:0] res_pi_reg, res_cnt_reg;
    logic [ID_W-1:0] res_id_reg;
    entry_t res_to_reg, res_from_reg;

    // nav result captured in ST_NAV1 (prev_reg holds current, rd_data previous)
    assign nav_res = (state_reg == ST_NAV1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= (state_reg == ST_DONE);
    end

    always_ff @(posedge clk)
    begin
        if (nav_res)
        begin
            res_to_reg    <= prev_reg;
            res_route_reg <= (cur_reg != '0);
            if (cur_reg != '0)
                res_from_reg <= rd_data;
            else
                res_from_reg <= '0;
        end
        else if (state_reg == ST_IDLE)
        begin
            res_to_reg    <= '0;
            res_from_reg  <= '0;
            res_route_reg <= 1'b0;
        end
        if (state_reg == ST_DONE)
        begin
            res_acc_reg <= acc_reg;
            res_ok_reg  <= ok_reg;
            res_pi_reg  <= 7'(cur_reg);
            res_cnt_reg <= 7'(count_reg);
            res_id_reg  <= (acc_reg && func_reg != FUNC_NAV) ? cmd_reg.id : '0;
        end
    end

    assign done        = res_valid_reg;
    assign accepted    = res_acc_reg;
    assign success     = res_ok_reg;
    assign path_index  = res_pi_reg;
    assign entry_count = res_cnt_reg;
    assign echo_id     = res_id_reg;
    assign route_mode  = res_route_reg;
    assign from_east   = res_from_reg.east;
    assign from_north  = res_from_reg.north;
    assign from_up     = res_from_reg.up;
    assign to_east     = res_to_reg.east;
    assign to_north    = res_to_reg.north;
    assign to_up       = res_to_reg.up;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH)) else $error("entry count overflow");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_DONE)) else $error("stray result strobe");
    a_no_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("transaction not taken");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(state_reg == ST_SHUP ||
        state_reg == ST_SHDN)) else $error("count changed outside shift");
`endif

endmodule
